/* rtl/core/fir15_line_filter_edge_replicate_unit_defines.svh */
// Assertion macros for the line filter unit.
// Included by the top level; depends on nothing else.
`ifndef FIR15_LINE_FILTER_EDGE_REPLICATE_UNIT_DEFINES_SVH
`define FIR15_LINE_FILTER_EDGE_REPLICATE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Checks that a property holds at every clock edge outside reset.
`define FLR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checks that an expression is never true outside reset.
`define FLR_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define FLR_ASSERT(lbl, clk, rstn, prop, msg)
`define FLR_ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

/* rtl/core/flr_pkg.sv */
// Shared constants and types of the line filter unit.
// Used by every file of the unit but the defines header; depends on nothing.
package flr_pkg;

  localparam int TAP_COUNT     = 15;
  localparam int BORDER_REPEAT = 7;
  localparam int MAX_LINE      = 4096;

  // Line position counter, wide enough to hold MAX_LINE - 1.
  localparam int LC_W  = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
  localparam int CMP_W = LC_W + 4;

  localparam int SMP_W   = 16;
  localparam int COEF_W  = 16;
  localparam int FRAC_W  = 16;
  localparam int PROD_W  = SMP_W + COEF_W;
  localparam int GRP_N   = 4;
  localparam int GRP_SZ  = 4;
  localparam int GRP_W   = PROD_W + 2;
  localparam int SUM_W   = PROD_W + 4;

  // Configuration port.
  localparam int CFG_W         = 64;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_REGS      = 4;
  localparam int TAPS_PER_WORD = CFG_W / COEF_W;

  // Command queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  // Flush sequencer steps: step 0 takes the sample, steps 1..7 replicate it.
  localparam int STEP_W = $clog2(BORDER_REPEAT + 1);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(BORDER_REPEAT);

  // One classified sample as handed from the front to the back.
  typedef struct packed {
    logic [SMP_W-1:0]  sample;
    logic              load_all;    // first sample of a line: fill the window
    logic              line_end;    // flush the rest of the line
    logic              emit;        // mid-line sample that yields an output
    logic [STEP_W-1:0] first_step;  // first flush step that yields an output
  } cmd_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

/* rtl/core/flr_if.sv */
// Stream interfaces of the line filter unit: input samples and filtered results.
// Depends on flr_pkg.
interface flr_in_if;
  logic                      valid;
  logic                      ready;
  logic [flr_pkg::SMP_W-1:0] sample;
  logic                      line_end;

  modport source (output valid, output sample, output line_end, input ready);
  modport sink (input valid, input sample, input line_end, output ready);
endinterface

interface flr_out_if;
  logic                      valid;
  logic                      ready;
  logic [flr_pkg::SMP_W-1:0] filtered;
  logic                      last_of_line;

  modport source (output valid, output filtered, output last_of_line, input ready);
  modport sink (input valid, input filtered, input last_of_line, output ready);
endinterface

/* rtl/core/fir15_line_filter_edge_replicate_unit.sv */
// Top level of the 15-tap line filter with replicated borders.
// Depends on flr_pkg, flr_if, flr_front, flr_queue, flr_back and the defines header.
//
// The unit filters each line of 16-bit samples with a 15-tap FIR whose
// coefficients are unsigned Q0.16, replicating the first and last sample of
// the line seven times at the borders. It takes one sample per clock while the
// command queue has room; a sample flagged as the line end holds the back end
// for eight flush steps on the shared 15-multiplier datapath. A four-entry
// command queue lets the input keep streaming during a flush until the queue
// fills. An output passes from the input beat that completes its window through
// the queue, the window, the products and the group sums, and then the rounded,
// saturated result sits in the output register. Coefficients must be written
// through the configuration port only while the unit is idle; the unit itself
// does not enforce this.
`include "fir15_line_filter_edge_replicate_unit_defines.svh"

module fir15_line_filter_edge_replicate_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [flr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [flr_pkg::CFG_W-1:0]     cfg_wdata_i,
  flr_in_if.sink                        in_i,
  flr_out_if.source                     out_o
);

  flr_pkg::cmd_t   push_cmd, head_cmd;
  flr_pkg::qstat_t qstat;
  logic            push, pop;

  // Front end: accept and classify samples.
  flr_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .qstat_i (qstat),
    .push_o  (push),
    .cmd_o   (push_cmd)
  );

  // Command queue.
  flr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head_cmd),
    .stat_o     (qstat)
  );

  // Back end: window, filter pipeline and output register.
  flr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .head_i      (head_cmd),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .out_o       (out_o)
  );

  // Queue bookkeeping checks.
  `FLR_ASSERT(a_push_room, clk_i, rst_ni, push |-> !qstat.full, "push into a full queue")
  `FLR_ASSERT(a_pop_data, clk_i, rst_ni, pop |-> !qstat.empty, "pop from an empty queue")
  `FLR_ASSERT_NEVER(a_q_status, clk_i, rst_ni, qstat.full && qstat.empty, "queue full and empty")

endmodule

/* rtl/core/flr_front.sv */
// Front end: accepts input beats, tracks the line position and classifies
// each sample into a command for the back end. Depends on flr_pkg and flr_if.
module flr_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  flr_in_if.sink           in_i,
  input  flr_pkg::qstat_t  qstat_i,
  output logic             push_o,
  output flr_pkg::cmd_t    cmd_o
);

  logic [flr_pkg::LC_W-1:0]  line_count_q, line_count_d;
  logic [flr_pkg::CMP_W-1:0] pos_ext;
  logic                      pos_ge_border;

  // Accept whenever the queue has room.
  assign in_i.ready = !qstat_i.full;
  assign push_o     = in_i.valid && in_i.ready;

  // Classify the sample by its place in the line.
  always_comb begin
    pos_ext       = flr_pkg::CMP_W'(line_count_q);
    pos_ge_border = pos_ext >= flr_pkg::CMP_W'(flr_pkg::BORDER_REPEAT);

    cmd_o.sample   = in_i.sample;
    cmd_o.load_all = (line_count_q == '0);
    cmd_o.line_end = in_i.line_end;
    cmd_o.emit     = pos_ge_border;
    if (pos_ge_border) begin
      cmd_o.first_step = '0;
    end else begin
      cmd_o.first_step = flr_pkg::STEP_W'(flr_pkg::CMP_W'(flr_pkg::BORDER_REPEAT) - pos_ext);
    end
  end

  // Line position saturates at MAX_LINE - 1 and restarts after a line end.
  always_comb begin
    line_count_d = line_count_q;
    if (push_o) begin
      if (in_i.line_end) begin
        line_count_d = '0;
      end else if (pos_ext < flr_pkg::CMP_W'(flr_pkg::MAX_LINE - 1)) begin
        line_count_d = line_count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_count_q <= '0;
    end else begin
      line_count_q <= line_count_d;
    end
  end

endmodule

/* rtl/core/flr_queue.sv */
// Short command queue between the front and the back end.
// Depends on flr_pkg.
module flr_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  flr_pkg::cmd_t    push_cmd_i,
  input  logic             pop_i,
  output flr_pkg::cmd_t    head_o,
  output flr_pkg::qstat_t  stat_o
);

  flr_pkg::cmd_t              entry_q [flr_pkg::QDEPTH];
  logic [flr_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [flr_pkg::QCNT_W-1:0] count_q;

  assign head_o       = entry_q[rd_ptr_q];
  assign stat_o.full  = (count_q == flr_pkg::QCNT_W'(flr_pkg::QDEPTH));
  assign stat_o.empty = (count_q == '0);

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/flr_back.sv */
// Back end: coefficient registers, sample window with the flush sequencer,
// and the multiply, add and round pipeline. Depends on flr_pkg and flr_if.
module flr_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [flr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [flr_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  flr_pkg::cmd_t                 head_i,
  input  flr_pkg::qstat_t               qstat_i,
  output logic                          pop_o,
  flr_out_if.source                     out_o
);

  logic [flr_pkg::COEF_W-1:0] coef_q [flr_pkg::TAP_COUNT];
  logic [flr_pkg::SMP_W-1:0]  win_q  [flr_pkg::TAP_COUNT];
  logic [flr_pkg::SMP_W-1:0]  win_d  [flr_pkg::TAP_COUNT];
  logic [flr_pkg::PROD_W-1:0] prod_q [flr_pkg::TAP_COUNT];
  logic [flr_pkg::GRP_W-1:0]  grp_q  [flr_pkg::GRP_N];
  logic [flr_pkg::GRP_W-1:0]  grp_d  [flr_pkg::GRP_N];
  logic [flr_pkg::STEP_W-1:0] step_q;
  logic                       v1_q, v2_q, v3_q, l1_q, l2_q, l3_q;
  logic                       advance, take, emit_now, last_now;
  logic [flr_pkg::SUM_W:0]    rnd;
  logic [flr_pkg::SMP_W-1:0]  result;
  logic                       out_valid_q, out_last_q;
  logic [flr_pkg::SMP_W-1:0]  out_data_q;

  // The whole pipeline moves when the output register is free or being drained.
  assign advance = !out_valid_q || out_o.ready;
  assign take    = advance && !qstat_i.empty;

  // A line end command stays at the head for all its flush steps.
  assign pop_o = take && (!head_i.line_end || step_q == flr_pkg::STEP_LAST);

  // Coefficient registers: tap t sits in word t / 4, slot t % 4.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < flr_pkg::TAP_COUNT; t++) begin
        coef_q[t] <= '0;
      end
    end else if (cfg_we_i) begin
      for (int t = 0; t < flr_pkg::TAP_COUNT; t++) begin
        if (cfg_idx_i == flr_pkg::CFG_IDX_W'(t / flr_pkg::TAPS_PER_WORD)) begin
          coef_q[t] <= cfg_wdata_i[(t % flr_pkg::TAPS_PER_WORD) * flr_pkg::COEF_W
                                   +: flr_pkg::COEF_W];
        end
      end
    end
  end

  // Window update and output decision for the current step.
  always_comb begin
    for (int i = 0; i < flr_pkg::TAP_COUNT - 1; i++) begin
      win_d[i] = win_q[i + 1];
    end
    win_d[flr_pkg::TAP_COUNT-1] = head_i.sample;
    if (step_q == '0 && head_i.load_all) begin
      for (int i = 0; i < flr_pkg::TAP_COUNT; i++) begin
        win_d[i] = head_i.sample;
      end
    end
    if (head_i.line_end) begin
      emit_now = (step_q >= head_i.first_step);
      last_now = (step_q == flr_pkg::STEP_LAST);
    end else begin
      emit_now = head_i.emit;
      last_now = 1'b0;
    end
  end

  // Flush step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (take) begin
      if (pop_o) begin
        step_q <= '0;
      end else begin
        step_q <= step_q + 1'b1;
      end
    end
  end

  // Adder tree first level: groups of up to four products.
  always_comb begin
    for (int g = 0; g < flr_pkg::GRP_N; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < flr_pkg::GRP_SZ; k++) begin
        if (g * flr_pkg::GRP_SZ + k < flr_pkg::TAP_COUNT) begin
          grp_d[g] = grp_d[g] + flr_pkg::GRP_W'(prod_q[g * flr_pkg::GRP_SZ + k]);
        end
      end
    end
  end

  // Final sum, round half up and saturate to the sample range.
  always_comb begin
    rnd = (flr_pkg::SUM_W + 1)'(1) << (flr_pkg::FRAC_W - 1);
    for (int g = 0; g < flr_pkg::GRP_N; g++) begin
      rnd = rnd + (flr_pkg::SUM_W + 1)'(grp_q[g]);
    end
    if (|rnd[flr_pkg::SUM_W:flr_pkg::FRAC_W + flr_pkg::SMP_W]) begin
      result = '1;
    end else begin
      result = rnd[flr_pkg::FRAC_W +: flr_pkg::SMP_W];
    end
  end

  // Datapath registers: window, products, group sums.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (take) begin
        win_q <= win_d;
      end
      for (int t = 0; t < flr_pkg::TAP_COUNT; t++) begin
        prod_q[t] <= flr_pkg::PROD_W'(coef_q[t]) *
                     flr_pkg::PROD_W'(win_q[flr_pkg::TAP_COUNT - 1 - t]);
      end
      grp_q <= grp_d;
    end
  end

  // Pipeline valid and last flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      l1_q <= 1'b0;
      l2_q <= 1'b0;
      l3_q <= 1'b0;
    end else if (advance) begin
      v1_q <= take && emit_now;
      l1_q <= last_now;
      v2_q <= v1_q;
      l2_q <= l1_q;
      v3_q <= v2_q;
      l3_q <= l2_q;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else if (advance) begin
      out_valid_q <= v3_q;
      out_last_q  <= l3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= result;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.filtered     = out_data_q;
  assign out_o.last_of_line = out_last_q;

endmodule
